### src/mcms_pkg.sv
// ----------------------------------------------------------------------------
// mcms_pkg
// shared types and codes of the march c memory test sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcms_pkg;

  // field widths of the stream and register interfaces
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned REG_SIZE_W  = 21;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 128;

  // reset values of the configuration registers
  localparam logic [ADDR_W-1:0]     RST_REGION_START = '0;
  localparam logic [REG_SIZE_W-1:0] RST_REGION_SIZE  = REG_SIZE_W'(1);
  localparam logic [BYTE_W-1:0]     RST_BACKGROUND   = 8'h55;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_START = 2'd0,
    CFG_REGION_SIZE  = 2'd1,
    CFG_BACKGROUND   = 2'd2
  } cfg_idx_e;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_ABORT = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  // run status as reported
  typedef enum logic [2:0] {
    ST_NOT_RUN = 3'd0,
    ST_RUNNING = 3'd1,
    ST_PASSED  = 3'd2,
    ST_FAILED  = 3'd3,
    ST_ABORTED = 3'd4
  } status_e;

  // march c elements in execution order
  typedef enum logic [2:0] {
    EL_UP_W0   = 3'd0,
    EL_UP_R0W1 = 3'd1,
    EL_UP_R1W0 = 3'd2,
    EL_DN_R0W1 = 3'd3,
    EL_DN_R1W0 = 3'd4,
    EL_UP_R0   = 3'd5
  } element_e;

  typedef struct packed {
    logic [ADDR_W-1:0]     region_start;
    logic [REG_SIZE_W-1:0] region_size;
    logic [BYTE_W-1:0]     background;
  } cfg_t;

  typedef struct packed {
    logic                  write_enable;
    logic [ADDR_W-1:0]     access_address;
    logic [BYTE_W-1:0]     write_byte;
    logic [ADDR_W-1:0]     next_address;
    status_e               status;
    logic [ADDR_W-1:0]     fail_address;
    logic [BYTE_W-1:0]     expected_byte;
    logic [BYTE_W-1:0]     actual_byte;
  } result_t;

endpackage

`default_nettype wire

### src/mcms_addr.sv
// ----------------------------------------------------------------------------
// mcms_addr
// test address from element, offset, effective size and region start
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcms_addr #(
  parameter int unsigned SIZE_W    = 21,
  parameter int unsigned ADDR_BITS = 32
) (
  input  wire mcms_pkg::element_e             element_i,
  input  wire logic [SIZE_W-1:0]              offset_i,
  input  wire logic [SIZE_W-1:0]              size_i,
  input  wire logic [mcms_pkg::ADDR_W-1:0]    start_i,
  output logic      [mcms_pkg::ADDR_W-1:0]    addr_o
);

  localparam int unsigned AW = (ADDR_BITS < mcms_pkg::ADDR_W) ? ADDR_BITS : mcms_pkg::ADDR_W;
  localparam logic [mcms_pkg::ADDR_W-1:0] MASK =
    mcms_pkg::ADDR_W'((64'd1 << AW) - 64'd1);

  logic                          descending;
  logic [mcms_pkg::ADDR_W-1:0]   pos;

  assign descending = (element_i == mcms_pkg::EL_DN_R0W1) ||
                      (element_i == mcms_pkg::EL_DN_R1W0);

  // descending elements walk from the top of the region
  assign pos = descending
             ? (mcms_pkg::ADDR_W'(size_i) - mcms_pkg::ADDR_W'(1) - mcms_pkg::ADDR_W'(offset_i))
             : mcms_pkg::ADDR_W'(offset_i);

  assign addr_o = (start_i + pos) & MASK;

endmodule

`default_nettype wire

### src/mcms_core.sv
// ----------------------------------------------------------------------------
// mcms_core
// march c run state and single-request step logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcms_core #(
  parameter int unsigned ADDR_BITS        = 32,
  parameter int unsigned MAX_REGION_BYTES = 1048576
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              fire_i,
  input  wire mcms_pkg::kind_e                   kind_i,
  input  wire logic [mcms_pkg::BYTE_W-1:0]       read_byte_i,
  input  wire mcms_pkg::cfg_t                    cfg_i,
  output mcms_pkg::result_t                      result_o
);

  localparam int unsigned SIZE_W = $clog2(MAX_REGION_BYTES + 1);
  localparam int unsigned CMP_W  = (SIZE_W > mcms_pkg::REG_SIZE_W) ? SIZE_W
                                                                    : mcms_pkg::REG_SIZE_W;
  localparam logic [CMP_W-1:0] MAX_SIZE = CMP_W'(MAX_REGION_BYTES);

  mcms_pkg::element_e               element_q, element_d;
  logic [SIZE_W-1:0]                offset_q, offset_d;
  mcms_pkg::status_e                status_q, status_d;
  logic [mcms_pkg::ADDR_W-1:0]      fail_addr_q, fail_addr_d;
  logic [mcms_pkg::BYTE_W-1:0]      expected_q, expected_d;
  logic [mcms_pkg::BYTE_W-1:0]      actual_q, actual_d;

  logic [CMP_W-1:0]                 size_ext;
  logic [SIZE_W-1:0]                size_eff;
  logic [mcms_pkg::BYTE_W-1:0]      bg;
  logic [mcms_pkg::BYTE_W-1:0]      inv;
  logic [mcms_pkg::BYTE_W-1:0]      expect_byte;
  logic [mcms_pkg::ADDR_W-1:0]      cur_addr;
  logic [mcms_pkg::ADDR_W-1:0]      nxt_addr;
  logic                             last_in_element;
  logic                             we;
  logic [mcms_pkg::BYTE_W-1:0]      wbyte;
  logic [mcms_pkg::ADDR_W-1:0]      acc_addr;

  // zero size counts as one byte, large sizes saturate
  always_comb begin
    size_ext = CMP_W'(cfg_i.region_size);
    if (size_ext == '0) begin
      size_ext = CMP_W'(1);
    end else if (size_ext > MAX_SIZE) begin
      size_ext = MAX_SIZE;
    end
  end
  assign size_eff = SIZE_W'(size_ext);

  assign bg  = cfg_i.background;
  assign inv = ~cfg_i.background;

  assign expect_byte = ((element_q == mcms_pkg::EL_UP_R1W0) ||
                        (element_q == mcms_pkg::EL_DN_R1W0)) ? inv : bg;

  assign last_in_element = ({1'b0, offset_q} + (SIZE_W + 1)'(1)) >= {1'b0, size_eff};

  mcms_addr #(
    .SIZE_W    (SIZE_W),
    .ADDR_BITS (ADDR_BITS)
  ) u_cur_addr (
    .element_i (element_q),
    .offset_i  (offset_q),
    .size_i    (size_eff),
    .start_i   (cfg_i.region_start),
    .addr_o    (cur_addr)
  );

  mcms_addr #(
    .SIZE_W    (SIZE_W),
    .ADDR_BITS (ADDR_BITS)
  ) u_nxt_addr (
    .element_i (element_d),
    .offset_i  (offset_d),
    .size_i    (size_eff),
    .start_i   (cfg_i.region_start),
    .addr_o    (nxt_addr)
  );

  always_comb begin
    element_d   = element_q;
    offset_d    = offset_q;
    status_d    = status_q;
    fail_addr_d = fail_addr_q;
    expected_d  = expected_q;
    actual_d    = actual_q;
    we          = 1'b0;
    wbyte       = '0;
    acc_addr    = '0;

    unique case (kind_i)
      mcms_pkg::KIND_START: begin
        if (status_q != mcms_pkg::ST_RUNNING) begin
          element_d   = mcms_pkg::EL_UP_W0;
          offset_d    = '0;
          status_d    = mcms_pkg::ST_RUNNING;
          fail_addr_d = '0;
          expected_d  = '0;
          actual_d    = '0;
        end
      end
      mcms_pkg::KIND_ABORT: begin
        if (status_q == mcms_pkg::ST_RUNNING) begin
          status_d = mcms_pkg::ST_ABORTED;
        end
      end
      mcms_pkg::KIND_STEP: begin
        if (status_q == mcms_pkg::ST_RUNNING) begin
          acc_addr = cur_addr;
          if ((element_q != mcms_pkg::EL_UP_W0) && (read_byte_i != expect_byte)) begin
            // first mismatch ends the run
            status_d    = mcms_pkg::ST_FAILED;
            fail_addr_d = cur_addr;
            expected_d  = expect_byte;
            actual_d    = read_byte_i;
          end else begin
            unique case (element_q)
              mcms_pkg::EL_UP_W0,
              mcms_pkg::EL_UP_R1W0,
              mcms_pkg::EL_DN_R1W0: begin
                we    = 1'b1;
                wbyte = bg;
              end
              mcms_pkg::EL_UP_R0W1,
              mcms_pkg::EL_DN_R0W1: begin
                we    = 1'b1;
                wbyte = inv;
              end
              default: begin
                we    = 1'b0;
                wbyte = '0;
              end
            endcase
            if (last_in_element) begin
              offset_d = '0;
              if (element_q >= mcms_pkg::EL_UP_R0) begin
                element_d = mcms_pkg::EL_UP_W0;
                status_d  = mcms_pkg::ST_PASSED;
              end else begin
                element_d = mcms_pkg::element_e'(element_q + 3'd1);
              end
            end else begin
              offset_d = offset_q + SIZE_W'(1);
            end
          end
        end
      end
      default: begin
        // no operation
      end
    endcase
  end

  always_comb begin
    result_o.write_enable   = we;
    result_o.access_address = acc_addr;
    result_o.write_byte     = wbyte;
    result_o.next_address   = (status_d == mcms_pkg::ST_RUNNING) ? nxt_addr : '0;
    result_o.status         = status_d;
    result_o.fail_address   = fail_addr_d;
    result_o.expected_byte  = expected_d;
    result_o.actual_byte    = actual_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_q   <= mcms_pkg::EL_UP_W0;
      offset_q    <= '0;
      status_q    <= mcms_pkg::ST_NOT_RUN;
      fail_addr_q <= '0;
      expected_q  <= '0;
      actual_q    <= '0;
    end else if (fire_i) begin
      element_q   <= element_d;
      offset_q    <= offset_d;
      status_q    <= status_d;
      fail_addr_q <= fail_addr_d;
      expected_q  <= expected_d;
      actual_q    <= actual_d;
    end
  end

endmodule

`default_nettype wire

### src/march_c_memory_test_sequencer.sv
// ----------------------------------------------------------------------------
// march_c_memory_test_sequencer
// byte-wide march c test sequencer driven one memory access per request
// ----------------------------------------------------------------------------
// The block runs (w0) up(r0,w1) up(r1,w0) down(r0,w1) down(r1,w0) up(r0)
// over the configured region, where 0 is the background byte and 1 its
// complement. A start request arms a run, each step request carries the byte
// read at the address last reported as next_address and returns the write to
// do there, the address checked and the next address; abort ends a run. The
// first mismatch stops the run and latches address, expected and actual
// byte. Every request gives exactly one result. Throughput is one request per
// clock while the result side is ready; a request passes the input register
// and then the result register, with the step logic between them. Either
// stream side may stall freely. Region registers may be rewritten between
// requests and apply to the next request.
`timescale 1ns / 1ps
`default_nettype none

module march_c_memory_test_sequencer #(
  parameter int unsigned ADDR_BITS        = 32,
  parameter int unsigned MAX_REGION_BYTES = 1048576
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,

  // configuration writes
  input  wire logic                                 cfg_we_i,
  input  wire logic [mcms_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [mcms_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,

  // request stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [mcms_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [7:0] read_byte
  input  wire logic [mcms_pkg::KIND_W-1:0]          s_axis_tuser,  // [1:0] kind

  // result stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [0] write_enable, [32:1] access_address, [40:33] write_byte,
  // [72:41] next_address, [75:73] status, [107:76] fail_address,
  // [115:108] expected_byte, [123:116] actual_byte, [127:124] zero
  output logic [mcms_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);

  localparam int unsigned RES_W = $bits(mcms_pkg::result_t);

  mcms_pkg::cfg_t                    cfg_q;

  // input register
  logic                              in_vld_q;
  mcms_pkg::kind_e                   in_kind_q;
  logic [mcms_pkg::BYTE_W-1:0]       in_rbyte_q;

  // result register
  logic                              out_vld_q;
  mcms_pkg::result_t                 out_q;

  mcms_pkg::result_t                 result;
  logic                              fire;
  logic                              in_take;

  // step when the input stage holds a request and the result slot frees up
  assign fire          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || fire;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // configuration registers, indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.region_start <= mcms_pkg::RST_REGION_START;
      cfg_q.region_size  <= mcms_pkg::RST_REGION_SIZE;
      cfg_q.background   <= mcms_pkg::RST_BACKGROUND;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mcms_pkg::CFG_REGION_START: cfg_q.region_start <= cfg_wdata_i;
        mcms_pkg::CFG_REGION_SIZE:
          cfg_q.region_size <= cfg_wdata_i[mcms_pkg::REG_SIZE_W-1:0];
        mcms_pkg::CFG_BACKGROUND:
          cfg_q.background <= cfg_wdata_i[mcms_pkg::BYTE_W-1:0];
        default: begin
          // unmapped index
        end
      endcase
    end
  end

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q  <= mcms_pkg::kind_e'(s_axis_tuser);
      in_rbyte_q <= s_axis_tdata[mcms_pkg::BYTE_W-1:0];
    end
  end

  mcms_core #(
    .ADDR_BITS        (ADDR_BITS),
    .MAX_REGION_BYTES (MAX_REGION_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .kind_i      (in_kind_q),
    .read_byte_i (in_rbyte_q),
    .cfg_i       (cfg_q),
    .result_o    (result)
  );

  // result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result stage payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;

  // pack fields from the lowest bit up
  assign m_axis_tdata = {
    (mcms_pkg::OUT_DATA_W - RES_W)'(0),
    out_q.actual_byte,
    out_q.expected_byte,
    out_q.fail_address,
    out_q.status,
    out_q.next_address,
    out_q.write_byte,
    out_q.access_address,
    out_q.write_enable
  };

  // a stepped request always lands in the result register
  a_fire_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("stepped request did not reach the result register");

  // a write only comes from a step that did not fail
  a_write_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.write_enable |->
      (out_q.status == mcms_pkg::ST_RUNNING) || (out_q.status == mcms_pkg::ST_PASSED))
    else $error("write issued outside a good step");

  // next address only reported during a run
  a_next_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.status != mcms_pkg::ST_RUNNING) |-> out_q.next_address == '0)
    else $error("next address reported without a run");

  // captures stay clear unless the latest run failed
  a_capture_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.status != mcms_pkg::ST_FAILED) |->
      (out_q.fail_address == '0) && (out_q.expected_byte == '0) &&
      (out_q.actual_byte == '0))
    else $error("failure capture set without a failed run");

endmodule

`default_nettype wire

### tb/tb_march_c_memory_test_sequencer.sv
// ----------------------------------------------------------------------------
// tb_march_c_memory_test_sequencer
// self-checking bench for the byte-wide march c test sequencer
// ----------------------------------------------------------------------------
// A short directed table runs first with the results typed in: requests while
// no run is active, a full pass over a one-byte region, an early mismatch, an
// abort and the ignored cases. Random phases follow. Each phase reprograms
// the region while the block is idle, then drives mostly clean march c runs
// with the right read bytes, plus sparse corrupted reads, aborts, no-ops and
// repeated starts. A bit-level model of the sequencer inside the bench
// predicts every result. Both stream sides stall in random bursts, the
// result side holds off once for a long stretch, and the tail runs at full
// rate.
`timescale 1ns / 1ps

module tb_march_c_memory_test_sequencer;
  import mcms_pkg::*;

  localparam int unsigned WORK_ITEMS  = 1050;   // random requests that do work
  localparam int unsigned QUIET_TAIL  = 120;    // requests at the end with no stalls
  localparam int unsigned HOLD_AT     = 300;    // when the long result hold-off starts
  localparam int unsigned LONG_HOLD   = 400;    // cycles of that hold-off
  localparam int unsigned DRAIN_WAIT  = 10;     // settle time after the last result
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned MAX_REPORTS = 100;
  localparam int unsigned SIZE_CAP    = 1048576;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register behind it

  // typed results for the directed table (reset region: address 0, one byte,
  // background 0x55)
  localparam result_t R_NOT_RUN  = '{1'b0, 32'h0, 8'h00, 32'h0, ST_NOT_RUN, 32'h0, 8'h00, 8'h00};
  localparam result_t R_ARMED    = '{1'b0, 32'h0, 8'h00, 32'h0, ST_RUNNING, 32'h0, 8'h00, 8'h00};
  localparam result_t R_WR_BG    = '{1'b1, 32'h0, 8'h55, 32'h0, ST_RUNNING, 32'h0, 8'h00, 8'h00};
  localparam result_t R_WR_INV   = '{1'b1, 32'h0, 8'hAA, 32'h0, ST_RUNNING, 32'h0, 8'h00, 8'h00};
  localparam result_t R_PASSED   = '{1'b0, 32'h0, 8'h00, 32'h0, ST_PASSED,  32'h0, 8'h00, 8'h00};
  localparam result_t R_FAILED   = '{1'b0, 32'h0, 8'h00, 32'h0, ST_FAILED,  32'h0, 8'h55, 8'h54};
  localparam result_t R_ABORTED  = '{1'b0, 32'h0, 8'h00, 32'h0, ST_ABORTED, 32'h0, 8'h00, 8'h00};

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] rd;
    result_t           res;
  } dir_row_t;

  localparam int unsigned N_DIR = 20;
  localparam dir_row_t DIR_TABLE [N_DIR] = '{
    '{KIND_STEP,  8'h3C, R_NOT_RUN},   // step with no run active
    '{KIND_NOP,   8'hFF, R_NOT_RUN},
    '{KIND_ABORT, 8'h00, R_NOT_RUN},   // abort with no run active is ignored
    '{KIND_START, 8'h00, R_ARMED},
    '{KIND_START, 8'hFF, R_ARMED},     // start while busy is ignored
    '{KIND_STEP,  8'hFF, R_WR_BG},     // up(w0): read byte not checked
    '{KIND_STEP,  8'h55, R_WR_INV},    // up(r0,w1)
    '{KIND_STEP,  8'hAA, R_WR_BG},     // up(r1,w0)
    '{KIND_STEP,  8'h55, R_WR_INV},    // down(r0,w1)
    '{KIND_STEP,  8'hAA, R_WR_BG},     // down(r1,w0)
    '{KIND_STEP,  8'h55, R_PASSED},    // up(r0) ends the run
    '{KIND_STEP,  8'h55, R_PASSED},
    '{KIND_START, 8'h80, R_ARMED},
    '{KIND_STEP,  8'h01, R_WR_BG},
    '{KIND_STEP,  8'h54, R_FAILED},    // first mismatch latches the captures
    '{KIND_NOP,   8'h00, R_FAILED},
    '{KIND_ABORT, 8'hC3, R_FAILED},
    '{KIND_START, 8'h00, R_ARMED},     // restart clears the captures
    '{KIND_ABORT, 8'h00, R_ABORTED},
    '{KIND_STEP,  8'h7F, R_ABORTED}
  };

  // dut ports
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] read_byte
  logic [KIND_W-1:0]     s_axis_tuser  = '0;   // [1:0] kind
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] write_enable, [32:1] access_address, [40:33] write_byte,
  // [72:41] next_address, [75:73] status, [107:76] fail_address,
  // [115:108] expected_byte, [123:116] actual_byte, [127:124] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // sequencer model: region registers and run state
  logic [ADDR_W-1:0]     rgn_start;
  logic [REG_SIZE_W-1:0] rgn_size;
  logic [BYTE_W-1:0]     rgn_bg;
  element_e              march_el;
  int unsigned           march_ofs;
  status_e               march_st;
  logic [ADDR_W-1:0]     cap_addr;
  logic [BYTE_W-1:0]     cap_want;
  logic [BYTE_W-1:0]     cap_got;

  result_t     march_results_due [$];
  int unsigned err_cnt       = 0;
  int unsigned cycle_cnt     = 0;
  bit          quiet_tail    = 1'b0;
  bit          long_hold_req = 1'b0;

  march_c_memory_test_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("march_c_memory_test_sequencer verification failed");
    $finish;
  end

  // region size as the march walks it: zero means one byte, large values clip
  function automatic int unsigned walk_size();
    if (rgn_size == '0) return 1;
    if (rgn_size > SIZE_CAP) return SIZE_CAP;
    return int'(rgn_size);
  endfunction

  // address of the current march position, descending in the down elements
  function automatic logic [ADDR_W-1:0] march_addr();
    logic [ADDR_W-1:0] pos;
    if (march_el == EL_DN_R0W1 || march_el == EL_DN_R1W0)
      pos = ADDR_W'(walk_size()) - 32'd1 - ADDR_W'(march_ofs);
    else
      pos = ADDR_W'(march_ofs);
    return rgn_start + pos;
  endfunction

  // one request through the model; returns the result it must produce
  function automatic result_t march_c_predict(kind_e kind, logic [BYTE_W-1:0] rd);
    result_t           res;
    logic [BYTE_W-1:0] want;
    res = '0;
    case (kind)
      KIND_START: begin
        if (march_st != ST_RUNNING) begin
          march_el  = EL_UP_W0;
          march_ofs = 0;
          march_st  = ST_RUNNING;
          cap_addr  = '0;
          cap_want  = '0;
          cap_got   = '0;
        end
      end
      KIND_ABORT: begin
        if (march_st == ST_RUNNING) march_st = ST_ABORTED;
      end
      KIND_STEP: begin
        if (march_st == ST_RUNNING) begin
          res.access_address = march_addr();
          // r1 elements read the complement, the others the background
          want = (march_el == EL_UP_R1W0 || march_el == EL_DN_R1W0) ? ~rgn_bg : rgn_bg;
          if (march_el != EL_UP_W0 && rd != want) begin
            march_st = ST_FAILED;
            cap_addr = res.access_address;
            cap_want = want;
            cap_got  = rd;
          end else begin
            if (march_el != EL_UP_R0) begin
              res.write_enable = 1'b1;
              res.write_byte   = (march_el == EL_UP_R0W1 || march_el == EL_DN_R0W1) ?
                                 ~rgn_bg : rgn_bg;
            end
            if (march_ofs + 1 >= walk_size()) begin
              march_ofs = 0;
              if (march_el == EL_UP_R0) begin
                march_el = EL_UP_W0;
                march_st = ST_PASSED;
              end else begin
                march_el = element_e'(march_el + 1);
              end
            end else begin
              march_ofs++;
            end
          end
        end
      end
      default: ;
    endcase
    if (march_st == ST_RUNNING) res.next_address = march_addr();
    res.status        = march_st;
    res.fail_address  = cap_addr;
    res.expected_byte = cap_want;
    res.actual_byte   = cap_got;
    return res;
  endfunction

  function automatic void check_field(string fname, logic [ADDR_W-1:0] want,
                                      logic [ADDR_W-1:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, fname, want, got);
    end
  endfunction

  // present one request and hold it until it is taken; the model steps at
  // the accepting edge. a typed result replaces the model's for the check
  task automatic send_request(kind_e kind, logic [BYTE_W-1:0] rd, bit typed,
                              result_t typed_res);
    result_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rd;
    s_axis_tuser  <= kind;
    // tready is stable by the falling edge, so this tells the next rising edge
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    res = march_c_predict(kind, rd);
    march_results_due.push_back(typed ? typed_res : res);
  endtask

  task automatic pause_requests(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_REGION_START: rgn_start = val;
      CFG_REGION_SIZE:  rgn_size  = val[REG_SIZE_W-1:0];
      CFG_BACKGROUND:   rgn_bg    = val[BYTE_W-1:0];
      default: ;
    endcase
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (march_results_due.size() != 0);
  endtask

  // result side: random stall bursts, one long hold-off, none in the tail
  always begin : result_sink
    int unsigned gap;
    @(posedge clk_i);
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      m_axis_tready <= 1'b0;
      repeat (LONG_HOLD) @(posedge clk_i);
      m_axis_tready <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 16);
      m_axis_tready <= 1'b0;
      repeat (gap) @(posedge clk_i);
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (march_results_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: result with none expected, actual 0x%0h", $time, m_axis_tdata);
      end else begin
        want = march_results_due.pop_front();
        check_field("write_enable",   32'(want.write_enable),  32'(m_axis_tdata[0]));
        check_field("access_address", want.access_address,     m_axis_tdata[32:1]);
        check_field("write_byte",     32'(want.write_byte),    32'(m_axis_tdata[40:33]));
        check_field("next_address",   want.next_address,       m_axis_tdata[72:41]);
        check_field("status",         32'(want.status),        32'(m_axis_tdata[75:73]));
        check_field("fail_address",   want.fail_address,       m_axis_tdata[107:76]);
        check_field("expected_byte",  32'(want.expected_byte), 32'(m_axis_tdata[115:108]));
        check_field("actual_byte",    32'(want.actual_byte),   32'(m_axis_tdata[123:116]));
        check_field("pad",            32'h0,                   32'(m_axis_tdata[127:124]));
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned       work_cnt;
    int unsigned       phase;
    int unsigned       phase_len;
    int unsigned       roll;
    bit                phase_idle;
    bit                busy;
    bit                hold_done;
    kind_e             kind;
    logic [BYTE_W-1:0] rd;
    logic [ADDR_W-1:0] new_start;
    logic [REG_SIZE_W-1:0] new_size;
    logic [BYTE_W-1:0] new_bg;

    rgn_start = RST_REGION_START;
    rgn_size  = RST_REGION_SIZE;
    rgn_bg    = RST_BACKGROUND;
    march_el  = EL_UP_W0;
    march_ofs = 0;
    march_st  = ST_NOT_RUN;
    cap_addr  = '0;
    cap_want  = '0;
    cap_got   = '0;
    work_cnt  = 0;
    hold_done = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at the reset region
    for (int i = 0; i < N_DIR; i++)
      send_request(DIR_TABLE[i].kind, DIR_TABLE[i].rd, 1'b1, DIR_TABLE[i].res);

    // random phases, each on a fresh region setting
    phase = 0;
    while (work_cnt < WORK_ITEMS) begin
      drain_results();
      case (phase)
        0: begin new_start = 32'hFFFF_FFFF; new_size = '0;           new_bg = 8'h00; end
        1: begin new_start = 32'hFFFF_FFF8; new_size = 21'd16;       new_bg = 8'hFF; end
        2: begin
          new_start = 32'h0;    new_size = 21'(SIZE_CAP); new_bg = 8'($urandom);
        end
        3: begin
          new_start = $urandom; new_size = 21'h1F_FFFF;   new_bg = 8'($urandom);
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       new_start = 32'h0;
            1:       new_start = 32'hFFFF_FFFF - $urandom_range(0, 30);
            default: new_start = $urandom;
          endcase
          case ($urandom_range(0, 19))
            0:       new_size = '0;
            1:       new_size = 21'd1;
            2:       new_size = 21'(SIZE_CAP);
            3:       new_size = 21'h1F_FFFF;
            4, 5, 6: new_size = 21'($urandom_range(9, 24));
            default: new_size = 21'($urandom_range(2, 8));
          endcase
          case ($urandom_range(0, 3))
            0:       new_bg = 8'h00;
            1:       new_bg = 8'hFF;
            default: new_bg = 8'($urandom);
          endcase
        end
      endcase
      // upper data bits beyond the register width are don't-care
      write_reg(CFG_REGION_START, new_start);
      write_reg(CFG_REGION_SIZE, {11'($urandom), new_size});
      write_reg(CFG_BACKGROUND, {24'($urandom), new_bg});
      if (phase == 2 || $urandom_range(0, 7) == 0)
        write_reg(CFG_UNUSED, $urandom);
      cfg_we_i <= 1'b0;

      phase_len  = $urandom_range(40, 110);
      phase_idle = ($urandom_range(0, 2) != 0);
      for (int n = 0; n < phase_len && work_cnt < WORK_ITEMS; n++) begin
        busy = (march_st == ST_RUNNING);
        rd   = 8'($urandom);
        if (busy) begin
          roll = $urandom_range(0, 199);
          if (roll < 4)       kind = KIND_ABORT;
          else if (roll < 10) kind = KIND_NOP;
          else if (roll < 13) kind = KIND_START;
          else begin
            kind = KIND_STEP;
            // the byte a healthy memory returns at this point of the march
            case (march_el)
              EL_UP_W0:               rd = 8'($urandom);
              EL_UP_R1W0, EL_DN_R1W0: rd = ~rgn_bg;
              default:                rd = rgn_bg;
            endcase
            if (roll < 16) rd = rd ^ (8'd1 << $urandom_range(0, 7));
          end
        end else begin
          kind = ($urandom_range(0, 4) != 0) ? KIND_START : kind_e'($urandom_range(0, 3));
        end
        if (busy || kind == KIND_START) work_cnt++;
        if (work_cnt >= WORK_ITEMS - QUIET_TAIL) quiet_tail = 1'b1;
        if (!hold_done && work_cnt >= HOLD_AT) begin
          hold_done     = 1'b1;
          long_hold_req = 1'b1;
        end
        send_request(kind, rd, 1'b0, '0);
        if (!quiet_tail && phase_idle && $urandom_range(0, 9) == 0)
          pause_requests($urandom_range(1, 16));
      end
      phase++;
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0 && march_results_due.size() == 0) begin
      $display("march_c_memory_test_sequencer verification clean");
    end else begin
      $display("march_c_memory_test_sequencer verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/mcms_pkg.sv
src/mcms_addr.sv
src/mcms_core.sv
src/march_c_memory_test_sequencer.sv
tb/tb_march_c_memory_test_sequencer.sv
